### rtl/vsd_pkg.sv
// Types, codes and constants shared by the ventilation state detector.
// No dependencies; imported by vsd_update and the core top level.
package vsd_pkg;

    // Climate state machine, one-hot.
    typedef enum logic [3:0] {
        ST_STABLE = 4'b0001,
        ST_VENT   = 4'b0010,
        ST_TARGET = 4'b0100,
        ST_INEFF  = 4'b1000
    } climate_t;

    // Output state codes.
    localparam logic [1:0] CS_STABLE = 2'd0;
    localparam logic [1:0] CS_VENT   = 2'd1;
    localparam logic [1:0] CS_TARGET = 2'd2;
    localparam logic [1:0] CS_INEFF  = 2'd3;

    // Transition codes.
    localparam logic [3:0] TR_NONE              = 4'd0;
    localparam logic [3:0] TR_STABLE_VENT       = 4'd1;
    localparam logic [3:0] TR_VENT_TARGET       = 4'd2;
    localparam logic [3:0] TR_VENT_INEFF        = 4'd3;
    localparam logic [3:0] TR_VENT_TEMP_REB     = 4'd4;
    localparam logic [3:0] TR_VENT_ABS_REB      = 4'd5;
    localparam logic [3:0] TR_TARGET_TEMP_REB   = 4'd6;
    localparam logic [3:0] TR_TARGET_ABS_REB    = 4'd7;
    localparam logic [3:0] TR_TARGET_TIMEOUT    = 4'd8;
    localparam logic [3:0] TR_INEFF_TEMP_REB    = 4'd9;
    localparam logic [3:0] TR_INEFF_ABS_REB     = 4'd10;
    localparam logic [3:0] TR_INEFF_TIMEOUT     = 4'd11;

    // Register indexes.
    localparam logic [2:0] REG_HUM_DROP      = 3'd0;
    localparam logic [2:0] REG_TEMP_DROP     = 3'd1;
    localparam logic [2:0] REG_ABSHUM_DROP   = 3'd2;
    localparam logic [2:0] REG_TRIG_CONFIRM  = 3'd3;
    localparam logic [2:0] REG_PLATEAU_THR   = 3'd4;
    localparam logic [2:0] REG_PLAT_CONFIRM  = 3'd5;
    localparam logic [2:0] REG_REB_TEMP      = 3'd6;
    localparam logic [2:0] REG_REB_ABSHUM    = 3'd7;

    // Timing and scaling constants.
    localparam logic [31:0] LOCKOUT_MS       = 32'd60000;
    localparam logic [31:0] REBOUND_MS       = 32'd60000;
    localparam logic [31:0] PLATEAU_MIN_MS   = 32'd180000;
    localparam logic [31:0] END_TIMEOUT_MS   = 32'd3600000;
    localparam logic [6:0]  BASELINE_PERIOD  = 7'd50;
    localparam logic [13:0] TARGET_DROP      = 14'd1500;
    localparam logic [13:0] TARGET_FLOOR     = 14'd5000;
    localparam logic [13:0] FACTOR_LO        = 14'd5000;
    localparam logic [13:0] FACTOR_HI        = 14'd7000;
    localparam logic signed [27:0] PLATEAU_SCALE = 28'sd100;
    localparam logic signed [27:0] FACTOR_SCALE  = 28'sd3;
    localparam logic signed [15:0] REB_TEMP_MARGIN = 16'sd5;
    localparam int SLOPE_MIN = 3;

    typedef struct packed {
        logic [13:0]        hum_drop_trigger;
        logic [12:0]        temp_drop_trigger;
        logic [16:0]        abshum_drop_trigger;
        logic [3:0]         trigger_confirm;
        logic signed [17:0] plateau_threshold;
        logic [3:0]         plateau_confirm;
        logic [12:0]        reb_temp_rise;
        logic [16:0]        reb_abshum_rise;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        hum_drop_trigger:    14'd300,
        temp_drop_trigger:   13'd100,
        abshum_drop_trigger: 17'd300,
        trigger_confirm:     4'd2,
        plateau_threshold:   -18'sd50,
        plateau_confirm:     4'd2,
        reb_temp_rise:       13'd30,
        reb_abshum_rise:     17'd500
    };

    typedef struct packed {
        logic               mode;
        logic signed [14:0] temperature;
        logic [13:0]        humidity;
        logic [16:0]        abs_humidity;
        logic [31:0]        time_ms;
    } item_t;

    typedef struct packed {
        climate_t           state;
        logic [31:0]        enter_time;
        logic signed [14:0] base_temp;
        logic [13:0]        base_hum;
        logic [16:0]        base_abshum;
        logic               base_valid;
        logic [16:0]        prev_abshum;
        logic [16:0]        latest_abshum;
        logic [3:0]         trigger_count;
        logic [3:0]         plateau_count;
        logic [5:0]         baseline_count;
        logic signed [14:0] rebound_temp;
        logic               rebound_valid;
        logic [31:0]        rebound_time;
        logic [13:0]        enter_hum;
    } ctx_t;

    localparam ctx_t CTX_RST = '{
        state:          ST_STABLE,
        enter_time:     32'd0,
        base_temp:      15'sd0,
        base_hum:       14'd0,
        base_abshum:    17'd0,
        base_valid:     1'b0,
        prev_abshum:    17'd0,
        latest_abshum:  17'd0,
        trigger_count:  4'd0,
        plateau_count:  4'd0,
        baseline_count: 6'd0,
        rebound_temp:   15'sd0,
        rebound_valid:  1'b0,
        rebound_time:   32'd0,
        enter_hum:      14'd0
    };

    // Newest and oldest samples of the slope window.
    typedef struct packed {
        logic        enough;
        logic [16:0] newest;
        logic [16:0] oldest;
    } slope_view_t;

    // Sample line control back to the top level.
    typedef struct packed {
        logic push;
        logic clear;
    } ring_ctl_t;

    typedef struct packed {
        logic [1:0] climate_state;
        logic [3:0] transition;
        logic       baseline_updated;
    } result_t;

    function automatic logic [1:0] state_code(climate_t s);
        logic [1:0] c;
        case (s)
            ST_STABLE: c = CS_STABLE;
            ST_VENT:   c = CS_VENT;
            ST_TARGET: c = CS_TARGET;
            ST_INEFF:  c = CS_INEFF;
            default:   c = CS_STABLE;
        endcase
        return c;
    endfunction

endpackage

### rtl/ventilation_state_detector_core.sv
// Ventilation state detector top level: stream ports, APB registers,
// input and result registers, and the slope sample line. Uses vsd_pkg, vsd_update.
//
//  channel   | ports             | word
//  ----------+-------------------+-------------------------------------------
//  input     | s_tvalid/s_tready | s_tuser: mode; s_tdata: readings and time
//  result    | m_tvalid/m_tready | m_tdata: state, transition, baseline flag
//  registers | APB psel/penable  | eight control registers at 4*index
//
// One word is accepted every cycle while s_tready is high; its result reaches m_tdata
// through the input register, one pass through the update logic and the result
// register.
// The input and result stages advance together; when the result is not taken,
// the input stage holds and s_tready drops only once that stage is also full.
// Reset (aresetn low, synchronous) clears the machine and restores the
// register defaults; sample line contents are not cleared.
module ventilation_state_detector_core #(
    parameter int SLOPE_DEPTH = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // temperature, humidity, abs_humidity, time_ms, zero pad
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // climate_state, transition, baseline_updated, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vsd_pkg::*;

    localparam int CNT_W = $clog2(SLOPE_DEPTH + 1);

    cfg_t              cfg_reg;
    ctx_t              ctx_reg, ctx_next;
    item_t             item_reg;
    logic              in_valid_reg;
    result_t           out_reg, result;
    logic              out_valid_reg;
    logic [16:0]       ring_reg [SLOPE_DEPTH];
    logic [16:0]       first_reg;
    logic [CNT_W-1:0]  count_reg;
    slope_view_t       slope;
    ring_ctl_t         ring;
    logic              advance, fire, cfg_wr;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = advance && in_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.baseline_updated, out_reg.transition,
                       out_reg.climate_state};

    // Once the line is full its last tap is the oldest sample; before that,
    // the first sample since the return to stable is.
    assign slope.enough = count_reg >= CNT_W'(SLOPE_MIN);
    assign slope.newest = ring_reg[0];
    assign slope.oldest = (count_reg == CNT_W'(SLOPE_DEPTH)) ? ring_reg[SLOPE_DEPTH-1]
                                                             : first_reg;

    vsd_update u_update (
        .cfg      (cfg_reg),
        .ctx      (ctx_reg),
        .item     (item_reg),
        .slope    (slope),
        .ctx_next (ctx_next),
        .ring     (ring),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= CTX_RST;
            count_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
                if (ring.clear) begin
                    count_reg <= '0;
                end else if (ring.push && count_reg < CNT_W'(SLOPE_DEPTH)) begin
                    count_reg <= count_reg + 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode         <= s_tuser[0];
            item_reg.temperature  <= s_tdata[14:0];
            item_reg.humidity     <= s_tdata[28:15];
            item_reg.abs_humidity <= s_tdata[45:29];
            item_reg.time_ms      <= s_tdata[77:46];
        end
        if (fire) begin
            out_reg <= result;
        end
        if (fire && ring.push) begin
            ring_reg[0] <= ctx_reg.latest_abshum;
            for (int i = 1; i < SLOPE_DEPTH; i++) begin
                ring_reg[i] <= ring_reg[i-1];
            end
            if (count_reg == '0) begin
                first_reg <= ctx_reg.latest_abshum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_HUM_DROP:     cfg_reg.hum_drop_trigger    <= pwdata[13:0];
                REG_TEMP_DROP:    cfg_reg.temp_drop_trigger   <= pwdata[12:0];
                REG_ABSHUM_DROP:  cfg_reg.abshum_drop_trigger <= pwdata[16:0];
                REG_TRIG_CONFIRM: cfg_reg.trigger_confirm     <= pwdata[3:0];
                REG_PLATEAU_THR:  cfg_reg.plateau_threshold   <= pwdata[17:0];
                REG_PLAT_CONFIRM: cfg_reg.plateau_confirm     <= pwdata[3:0];
                REG_REB_TEMP:     cfg_reg.reb_temp_rise       <= pwdata[12:0];
                REG_REB_ABSHUM:   cfg_reg.reb_abshum_rise     <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HUM_DROP:     prdata = {18'd0, cfg_reg.hum_drop_trigger};
            REG_TEMP_DROP:    prdata = {19'd0, cfg_reg.temp_drop_trigger};
            REG_ABSHUM_DROP:  prdata = {15'd0, cfg_reg.abshum_drop_trigger};
            REG_TRIG_CONFIRM: prdata = {28'd0, cfg_reg.trigger_confirm};
            REG_PLATEAU_THR:  prdata = {{14{cfg_reg.plateau_threshold[17]}},
                                        cfg_reg.plateau_threshold};
            REG_PLAT_CONFIRM: prdata = {28'd0, cfg_reg.plateau_confirm};
            REG_REB_TEMP:     prdata = {19'd0, cfg_reg.reb_temp_rise};
            REG_REB_ABSHUM:   prdata = {15'd0, cfg_reg.reb_abshum_rise};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

### rtl/vsd_update.sv
// Next-state logic of the ventilation state detector for one word.
// Depends on vsd_pkg; purely combinational, registered in the top level.
module vsd_update (
    input  vsd_pkg::cfg_t        cfg,
    input  vsd_pkg::ctx_t        ctx,
    input  vsd_pkg::item_t       item,
    input  vsd_pkg::slope_view_t slope,
    output vsd_pkg::ctx_t        ctx_next,
    output vsd_pkg::ring_ctl_t   ring,
    output vsd_pkg::result_t     result
);
    import vsd_pkg::*;

    logic signed [14:0] t, bt;
    logic [13:0]        h, bh;
    logic [16:0]        a, ba, pa;
    logic [31:0]        now, dt, rdur;
    logic signed [15:0] hum_diff;
    logic signed [16:0] temp_diff;
    logic signed [17:0] abs_drop, abs_rise;
    logic               trig, lockout;
    logic [3:0]         tc_inc, pc_inc;
    logic [6:0]         bc_inc;
    logic signed [14:0] tgt_s;
    logic [13:0]        tgt, fclamp;
    logic [10:0]        f;
    logic signed [17:0] slope_d;
    logic signed [27:0] lhs, rhs, slope_x, thr_x, f_x;
    logic               flat;
    logic signed [15:0] rise;
    logic               rb_fire_temp, rb_clear, rb_start, rb_fire_abs;
    logic               reload, vent_stay;
    logic [3:0]         code, c_temp, c_abs, c_tmo;

    always_comb begin
        t   = item.temperature;
        h   = item.humidity;
        a   = item.abs_humidity;
        now = item.time_ms;

        // The very first reading stands in for the baseline.
        bt = ctx.base_valid ? ctx.base_temp   : t;
        bh = ctx.base_valid ? ctx.base_hum    : h;
        ba = ctx.base_valid ? ctx.base_abshum : a;
        pa = ctx.base_valid ? ctx.prev_abshum : a;

        dt      = now - ctx.enter_time;
        lockout = dt < LOCKOUT_MS;

        hum_diff  = $signed({2'b00, bh}) - $signed({2'b00, h});
        temp_diff = $signed({{2{bt[14]}}, bt}) - $signed({{2{t[14]}}, t});
        abs_drop  = $signed({1'b0, pa}) - $signed({1'b0, a});
        trig = (hum_diff > $signed({2'b00, cfg.hum_drop_trigger}))
            || (temp_diff > $signed({4'b0000, cfg.temp_drop_trigger}))
            || (abs_drop > $signed({1'b0, cfg.abshum_drop_trigger}));

        tc_inc = (ctx.trigger_count == 4'hF) ? 4'hF : ctx.trigger_count + 4'd1;
        pc_inc = (ctx.plateau_count == 4'hF) ? 4'hF : ctx.plateau_count + 4'd1;
        bc_inc = {1'b0, ctx.baseline_count} + 7'd1;

        tgt_s = $signed({1'b0, ctx.enter_hum}) - $signed({1'b0, TARGET_DROP});
        tgt   = (tgt_s < $signed({1'b0, TARGET_FLOOR})) ? TARGET_FLOOR : tgt_s[13:0];

        if (ctx.enter_hum < FACTOR_LO) begin
            fclamp = FACTOR_LO;
        end else if (ctx.enter_hum > FACTOR_HI) begin
            fclamp = FACTOR_HI;
        end else begin
            fclamp = ctx.enter_hum;
        end
        f = 11'(fclamp - FACTOR_LO);

        // Plateau when 100*slope > 100*threshold - 3*f, done exactly.
        slope_d = $signed({1'b0, slope.newest}) - $signed({1'b0, slope.oldest});
        slope_x = {{10{slope_d[17]}}, slope_d};
        thr_x   = {{10{cfg.plateau_threshold[17]}}, cfg.plateau_threshold};
        f_x     = {17'd0, f};
        lhs     = slope_x * PLATEAU_SCALE;
        rhs     = thr_x * PLATEAU_SCALE - f_x * FACTOR_SCALE;
        flat    = lhs > rhs;

        rise     = $signed({t[14], t}) - $signed({ctx.rebound_temp[14], ctx.rebound_temp});
        rdur     = now - ctx.rebound_time;
        abs_rise = $signed({1'b0, a}) - $signed({1'b0, ba});
        rb_fire_temp = ctx.rebound_valid
            && (rise > $signed({3'b000, cfg.reb_temp_rise}))
            && (rdur > REBOUND_MS);
        rb_clear    = ctx.rebound_valid && !rb_fire_temp && (t < ctx.rebound_temp);
        rb_start    = !ctx.rebound_valid
            && ($signed({t[14], t}) > $signed({bt[14], bt}) + REB_TEMP_MARGIN);
        rb_fire_abs = !rb_fire_temp && (abs_rise > $signed({1'b0, cfg.reb_abshum_rise}));

        c_temp = (ctx.state == ST_TARGET) ? TR_TARGET_TEMP_REB : TR_INEFF_TEMP_REB;
        c_abs  = (ctx.state == ST_TARGET) ? TR_TARGET_ABS_REB  : TR_INEFF_ABS_REB;
        c_tmo  = (ctx.state == ST_TARGET) ? TR_TARGET_TIMEOUT  : TR_INEFF_TIMEOUT;

        ctx_next  = ctx;
        code      = TR_NONE;
        reload    = 1'b0;
        vent_stay = 1'b0;
        ring      = '0;

        if (item.mode) begin
            ring.push = (ctx.state != ST_STABLE);
        end else begin
            ctx_next.base_valid  = 1'b1;
            ctx_next.base_temp   = bt;
            ctx_next.base_hum    = bh;
            ctx_next.base_abshum = ba;

            case (ctx.state)
                ST_STABLE: begin
                    ctx_next.plateau_count = 4'd0;
                    ctx_next.rebound_valid = 1'b0;
                    if (trig && !lockout) begin
                        if (tc_inc >= cfg.trigger_confirm) begin
                            ctx_next.state         = ST_VENT;
                            code                   = TR_STABLE_VENT;
                            ctx_next.enter_time    = now;
                            reload                 = 1'b1;
                            ctx_next.enter_hum     = h;
                            ctx_next.trigger_count = 4'd0;
                        end else begin
                            ctx_next.trigger_count = tc_inc;
                        end
                    end else begin
                        ctx_next.trigger_count = 4'd0;
                    end
                    if (bc_inc >= BASELINE_PERIOD) begin
                        ctx_next.baseline_count = 6'd0;
                        reload                  = 1'b1;
                    end else begin
                        ctx_next.baseline_count = bc_inc[5:0];
                    end
                end
                ST_VENT: begin
                    if (h <= tgt) begin
                        ctx_next.state         = ST_TARGET;
                        code                   = TR_VENT_TARGET;
                        ctx_next.enter_time    = now;
                        reload                 = 1'b1;
                        ctx_next.rebound_valid = 1'b0;
                    end else begin
                        vent_stay = 1'b1;
                        if (dt > PLATEAU_MIN_MS && slope.enough) begin
                            if (flat) begin
                                ctx_next.plateau_count = pc_inc;
                                if (pc_inc >= cfg.plateau_confirm) begin
                                    ctx_next.state         = ST_INEFF;
                                    code                   = TR_VENT_INEFF;
                                    ctx_next.enter_time    = now;
                                    reload                 = 1'b1;
                                    ctx_next.rebound_valid = 1'b0;
                                    vent_stay              = 1'b0;
                                end
                            end else begin
                                ctx_next.plateau_count = 4'd0;
                            end
                        end
                    end
                    if (vent_stay) begin
                        if (rb_fire_temp) begin
                            ctx_next.state      = ST_STABLE;
                            code                = TR_VENT_TEMP_REB;
                            ctx_next.enter_time = now;
                            reload              = 1'b1;
                        end else begin
                            if (rb_clear) begin
                                ctx_next.rebound_valid = 1'b0;
                            end
                            if (rb_start) begin
                                ctx_next.rebound_temp  = bt;
                                ctx_next.rebound_time  = now;
                                ctx_next.rebound_valid = 1'b1;
                            end
                            if (rb_fire_abs) begin
                                ctx_next.state      = ST_STABLE;
                                code                = TR_VENT_ABS_REB;
                                ctx_next.enter_time = now;
                                reload              = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    // Target met and inefficient wait for a rebound or the timeout.
                    if (rb_fire_temp) begin
                        ctx_next.state      = ST_STABLE;
                        code                = c_temp;
                        ctx_next.enter_time = now;
                        reload              = 1'b1;
                    end else begin
                        if (rb_clear) begin
                            ctx_next.rebound_valid = 1'b0;
                        end
                        if (rb_start) begin
                            ctx_next.rebound_temp  = bt;
                            ctx_next.rebound_time  = now;
                            ctx_next.rebound_valid = 1'b1;
                        end
                        if (rb_fire_abs) begin
                            ctx_next.state      = ST_STABLE;
                            code                = c_abs;
                            ctx_next.enter_time = now;
                            reload              = 1'b1;
                        end else if (dt > END_TIMEOUT_MS) begin
                            ctx_next.state      = ST_STABLE;
                            code                = c_tmo;
                            ctx_next.enter_time = now;
                            reload              = 1'b1;
                        end
                    end
                end
            endcase

            if (reload) begin
                ctx_next.base_temp   = t;
                ctx_next.base_hum    = h;
                ctx_next.base_abshum = a;
            end
            ring.clear             = (ctx_next.state == ST_STABLE);
            ctx_next.prev_abshum   = a;
            ctx_next.latest_abshum = a;
        end

        result.climate_state    = state_code(ctx_next.state);
        result.transition       = code;
        result.baseline_updated = reload;
    end

endmodule
